// ----- design/bsp_pkg.sv -----
// shared types, codes and sizes of the bencode stream parser
`default_nettype none
package bsp_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int CMP_W       = (CNT_W > 7) ? CNT_W : 7;
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);
    localparam int MAXEV       = 3;
    localparam int ACC_W       = 63;

    localparam logic [6:0] DEPTH_LIMIT_RST = 7'd50;

    localparam logic [1:0] REQ_DATA    = 2'd0;
    localparam logic [1:0] REQ_CHECK   = 2'd1;
    localparam logic [1:0] REQ_RESTART = 2'd2;

    localparam logic [1:0] N_BOTTOM = 2'd0;
    localparam logic [1:0] N_KEY    = 2'd1;
    localparam logic [1:0] N_VAL    = 2'd2;
    localparam logic [1:0] N_LIST   = 2'd3;

    localparam logic [2:0] K_BEGIN  = 3'd0;
    localparam logic [2:0] K_END    = 3'd1;
    localparam logic [2:0] K_CHARS  = 3'd2;
    localparam logic [2:0] K_NUMBER = 3'd3;
    localparam logic [2:0] K_ERROR  = 3'd4;
    localparam logic [2:0] K_PASS   = 3'd5;

    localparam logic [2:0] E_DICT   = 3'd0;
    localparam logic [2:0] E_KEY    = 3'd1;
    localparam logic [2:0] E_DVAL   = 3'd2;
    localparam logic [2:0] E_LIST   = 3'd3;
    localparam logic [2:0] E_ITEM   = 3'd4;
    localparam logic [2:0] E_STRING = 3'd5;
    localparam logic [2:0] E_NUMBER = 3'd6;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_VAL_START = 3'd1;
    localparam logic [2:0] ERR_LEN_OVF   = 3'd2;
    localparam logic [2:0] ERR_BAD_LEN   = 3'd3;
    localparam logic [2:0] ERR_NUM_OVF   = 3'd4;
    localparam logic [2:0] ERR_BAD_NUM   = 3'd5;
    localparam logic [2:0] ERR_TOO_DEEP  = 3'd6;
    localparam logic [2:0] ERR_PREMATURE = 3'd7;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_L     = 8'h6c;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;

    typedef struct packed {
        logic [2:0] kind;
        logic [2:0] etype;
        logic [2:0] err;
    } ev_t;

    typedef struct packed {
        logic [1:0]            n;
        ev_t [MAXEV-1:0]       ev;
        logic [7:0]            chr;
        logic                  cnt;
        logic [63:0]           num;
    } bundle_t;

    function automatic ev_t mk_ev(input logic [2:0] kind, input logic [2:0] etype,
                                  input logic [2:0] err);
        ev_t e;
        e.kind  = kind;
        e.etype = etype;
        e.err   = err;
        return e;
    endfunction

endpackage
`default_nettype wire

// ----- design/bsp_ram.sv -----
// generic single-write ram with registered read
`default_nettype none
module bsp_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ----- design/bsp_front.sv -----
// front part: byte parsing, nesting stack, accumulators, event bundles
`default_nettype none
module bsp_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [1:0]          req_type,
    input  wire logic [7:0]          data_byte,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [6:0]          cfg_data,
    input  wire logic                q_full,
    output logic                     q_push,
    output bsp_pkg::bundle_t         q_data
);

    typedef enum logic [9:0] {
        ST_FINISH   = 10'b0000000001,
        ST_ERROR    = 10'b0000000010,
        ST_INITIAL  = 10'b0000000100,
        ST_VALUE    = 10'b0000001000,
        ST_DICT_KEY = 10'b0000010000,
        ST_LIST     = 10'b0000100000,
        ST_STR_LEN  = 10'b0001000000,
        ST_STRING   = 10'b0010000000,
        ST_NUM_SIGN = 10'b0100000000,
        ST_NUMBER   = 10'b1000000000
    } state_t;

    localparam int SADDR_W = $clog2(bsp_pkg::STACK_DEPTH);
    localparam int CNT_W   = bsp_pkg::CNT_W;
    localparam int CMP_W   = bsp_pkg::CMP_W;
    localparam int ACC_W   = bsp_pkg::ACC_W;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [1:0]             top_reg, top_next;
    logic [ACC_W-1:0]       len_reg, len_next;
    logic [ACC_W-1:0]       mag_reg, mag_next;
    logic                   neg_reg, neg_next;
    logic                   dig_reg, dig_next;
    logic [2:0]             err_reg, err_next;
    logic [6:0]             limit_reg;
    logic                   byp_valid_reg;
    logic [1:0]             byp_data_reg;

    logic                   fire;
    logic                   push_w;
    logic [1:0]             ram_rdata;
    logic [1:0]             below;
    logic [SADDR_W-1:0]     waddr;
    logic [SADDR_W-1:0]     raddr;
    logic [CNT_W-1:0]       wsum;
    logic [CNT_W-1:0]       rsum;
    logic [CMP_W-1:0]       lim;
    logic                   push_ok;
    logic                   is_dig;
    logic [3:0]             dval;
    logic [ACC_W-1:0]       acc_src;
    logic [ACC_W+3:0]       mul_sum;
    logic                   mul_ovf;
    logic [ACC_W-1:0]       rem;
    logic [63:0]            num_val;
    logic [2:0]             ct;
    logic                   ve_has;
    bsp_pkg::ev_t           ve_ev;
    state_t                 ve_state;
    logic                   ve_pop;
    logic [1:0]             ve_top;
    bsp_pkg::bundle_t       b;
    logic                   do_ve;
    logic                   do_bv;
    logic                   do_push;
    logic [1:0]             push_code;

    assign fire      = in_valid && in_ready;
    assign in_ready  = !q_full;
    assign cfg_ready = 1'b1;
    assign below     = byp_valid_reg ? byp_data_reg : ram_rdata;
    assign push_w    = fire && do_push && push_ok;

    assign wsum  = count_reg - CNT_W'(1);
    assign waddr = wsum[SADDR_W-1:0];
    assign rsum  = count_next - CNT_W'(2);
    assign raddr = rsum[SADDR_W-1:0];

    bsp_ram #(
        .WIDTH (2),
        .DEPTH (bsp_pkg::STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (push_w),
        .waddr (waddr),
        .wdata (top_reg),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        if (CMP_W'(limit_reg) > CMP_W'(bsp_pkg::STACK_DEPTH))
        begin
            lim = CMP_W'(bsp_pkg::STACK_DEPTH);
        end
        else
        begin
            lim = CMP_W'(limit_reg);
        end
        push_ok = CMP_W'(count_reg) < lim;
    end

    // digit accumulate, shared by length and number
    always_comb
    begin
        is_dig  = (data_byte >= bsp_pkg::CH_ZERO) && (data_byte <= bsp_pkg::CH_NINE);
        dval    = 4'(data_byte - bsp_pkg::CH_ZERO);
        acc_src = (state_reg == ST_NUMBER) ? mag_reg : len_reg;
        mul_sum = {1'b0, acc_src, 3'b000} + {3'b000, acc_src, 1'b0}
                + {{ACC_W{1'b0}}, dval};
        mul_ovf = |mul_sum[ACC_W+3:ACC_W];
        rem     = (len_reg != '0) ? len_reg - ACC_W'(1) : len_reg;
        num_val = neg_reg ? (64'd0 - {1'b0, mag_reg}) : {1'b0, mag_reg};
        ct      = (top_reg == bsp_pkg::N_KEY) ? bsp_pkg::E_KEY : bsp_pkg::E_STRING;
    end

    // close of a value, set by the enclosing entry
    always_comb
    begin
        ve_has   = 1'b0;
        ve_ev    = bsp_pkg::mk_ev(bsp_pkg::K_END, bsp_pkg::E_DVAL, bsp_pkg::ERR_NONE);
        ve_state = ST_FINISH;
        ve_pop   = 1'b0;
        ve_top   = top_reg;
        unique case (top_reg)
            bsp_pkg::N_KEY:
            begin
                ve_has   = 1'b1;
                ve_ev    = bsp_pkg::mk_ev(bsp_pkg::K_BEGIN, bsp_pkg::E_DVAL,
                                          bsp_pkg::ERR_NONE);
                ve_state = ST_VALUE;
                ve_top   = bsp_pkg::N_VAL;
            end
            bsp_pkg::N_VAL:
            begin
                ve_has   = 1'b1;
                ve_state = ST_DICT_KEY;
                ve_pop   = 1'b1;
            end
            bsp_pkg::N_LIST:
            begin
                ve_has   = 1'b1;
                ve_ev    = bsp_pkg::mk_ev(bsp_pkg::K_END, bsp_pkg::E_ITEM,
                                          bsp_pkg::ERR_NONE);
                ve_state = ST_LIST;
                ve_pop   = 1'b1;
            end
            default:
            begin
                ve_has = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        top_next   = top_reg;
        len_next   = len_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        dig_next   = dig_reg;
        err_next   = err_reg;
        b          = '0;
        do_ve      = 1'b0;
        do_bv      = 1'b0;
        do_push    = 1'b0;
        push_code  = bsp_pkg::N_LIST;

        if (req_type == bsp_pkg::REQ_DATA)
        begin
            unique case (state_reg)
                ST_ERROR:
                begin
                    b.ev[b.n] = bsp_pkg::mk_ev(bsp_pkg::K_ERROR, 3'd0, err_reg);
                    b.n = b.n + 2'd1;
                end
                ST_LIST:
                begin
                    if (data_byte == bsp_pkg::CH_E)
                    begin
                        b.ev[b.n] = bsp_pkg::mk_ev(bsp_pkg::K_END, bsp_pkg::E_LIST,
                                                   bsp_pkg::ERR_NONE);
                        b.n = b.n + 2'd1;
                        do_ve = 1'b1;
                    end
                    else
                    begin
                        do_push   = 1'b1;
                        push_code = bsp_pkg::N_LIST;
                        if (push_ok)
                        begin
                            b.ev[b.n] = bsp_pkg::mk_ev(bsp_pkg::K_BEGIN,
                                                       bsp_pkg::E_ITEM,
                                                       bsp_pkg::ERR_NONE);
                            b.n = b.n + 2'd1;
                            do_bv = 1'b1;
                        end
                    end
                end
                ST_INITIAL, ST_VALUE:
                begin
                    do_bv = 1'b1;
                end
                ST_DICT_KEY:
                begin
                    if (data_byte == bsp_pkg::CH_E)
                    begin
                        b.ev[b.n] = bsp_pkg::mk_ev(bsp_pkg::K_END, bsp_pkg::E_DICT,
                                                   bsp_pkg::ERR_NONE);
                        b.n = b.n + 2'd1;
                        do_ve = 1'b1;
                    end
                    else
                    begin
                        do_push   = 1'b1;
                        push_code = bsp_pkg::N_KEY;
                        if (push_ok)
                        begin
                            b.ev[b.n] = bsp_pkg::mk_ev(bsp_pkg::K_BEGIN,
                                                       bsp_pkg::E_KEY,
                                                       bsp_pkg::ERR_NONE);
                            b.n = b.n + 2'd1;
                            if (is_dig)
                            begin
                                len_next   = {{(ACC_W-4){1'b0}}, dval};
                                dig_next   = 1'b1;
                                state_next = ST_STR_LEN;
                            end
                            else
                            begin
                                err_next   = bsp_pkg::ERR_BAD_LEN;
                                state_next = ST_ERROR;
                                b.ev[b.n]  = bsp_pkg::mk_ev(bsp_pkg::K_ERROR, 3'd0,
                                                            bsp_pkg::ERR_BAD_LEN);
                                b.n = b.n + 2'd1;
                            end
                        end
                    end
                end
                ST_STR_LEN:
                begin
                    if (is_dig)
                    begin
                        if (mul_ovf)
                        begin
                            err_next   = bsp_pkg::ERR_LEN_OVF;
                            state_next = ST_ERROR;
                            b.ev[b.n]  = bsp_pkg::mk_ev(bsp_pkg::K_ERROR, 3'd0,
                                                        bsp_pkg::ERR_LEN_OVF);
                            b.n = b.n + 2'd1;
                        end
                        else
                        begin
                            len_next = mul_sum[ACC_W-1:0];
                            dig_next = 1'b1;
                        end
                    end
                    else if (data_byte == bsp_pkg::CH_COLON && dig_reg)
                    begin
                        state_next = ST_STRING;
                        if (len_reg == '0)
                        begin
                            b.ev[b.n] = bsp_pkg::mk_ev(bsp_pkg::K_CHARS, ct,
                                                       bsp_pkg::ERR_NONE);
                            b.n = b.n + 2'd1;
                            b.ev[b.n] = bsp_pkg::mk_ev(bsp_pkg::K_END, ct,
                                                       bsp_pkg::ERR_NONE);
                            b.n = b.n + 2'd1;
                            do_ve = 1'b1;
                        end
                    end
                    else
                    begin
                        err_next   = bsp_pkg::ERR_BAD_LEN;
                        state_next = ST_ERROR;
                        b.ev[b.n]  = bsp_pkg::mk_ev(bsp_pkg::K_ERROR, 3'd0,
                                                    bsp_pkg::ERR_BAD_LEN);
                        b.n = b.n + 2'd1;
                    end
                end
                ST_STRING:
                begin
                    b.ev[b.n] = bsp_pkg::mk_ev(bsp_pkg::K_CHARS, ct, bsp_pkg::ERR_NONE);
                    b.n   = b.n + 2'd1;
                    b.chr = data_byte;
                    b.cnt = 1'b1;
                    len_next = rem;
                    if (rem == '0)
                    begin
                        b.ev[b.n] = bsp_pkg::mk_ev(bsp_pkg::K_END, ct, bsp_pkg::ERR_NONE);
                        b.n = b.n + 2'd1;
                        do_ve = 1'b1;
                    end
                end
                ST_NUM_SIGN:
                begin
                    if (data_byte == bsp_pkg::CH_PLUS)
                    begin
                        neg_next   = 1'b0;
                        state_next = ST_NUMBER;
                    end
                    else if (data_byte == bsp_pkg::CH_MINUS)
                    begin
                        neg_next   = 1'b1;
                        state_next = ST_NUMBER;
                    end
                    else if (is_dig)
                    begin
                        mag_next   = {{(ACC_W-4){1'b0}}, dval};
                        dig_next   = 1'b1;
                        state_next = ST_NUMBER;
                    end
                    else
                    begin
                        err_next   = bsp_pkg::ERR_BAD_NUM;
                        state_next = ST_ERROR;
                        b.ev[b.n]  = bsp_pkg::mk_ev(bsp_pkg::K_ERROR, 3'd0,
                                                    bsp_pkg::ERR_BAD_NUM);
                        b.n = b.n + 2'd1;
                    end
                end
                ST_NUMBER:
                begin
                    if (is_dig)
                    begin
                        if (mul_ovf)
                        begin
                            err_next   = bsp_pkg::ERR_NUM_OVF;
                            state_next = ST_ERROR;
                            b.ev[b.n]  = bsp_pkg::mk_ev(bsp_pkg::K_ERROR, 3'd0,
                                                        bsp_pkg::ERR_NUM_OVF);
                            b.n = b.n + 2'd1;
                        end
                        else
                        begin
                            mag_next = mul_sum[ACC_W-1:0];
                            dig_next = 1'b1;
                        end
                    end
                    else if (data_byte == bsp_pkg::CH_E && dig_reg)
                    begin
                        b.ev[b.n] = bsp_pkg::mk_ev(bsp_pkg::K_NUMBER, bsp_pkg::E_NUMBER,
                                                   bsp_pkg::ERR_NONE);
                        b.n   = b.n + 2'd1;
                        b.num = num_val;
                        b.ev[b.n] = bsp_pkg::mk_ev(bsp_pkg::K_END, bsp_pkg::E_NUMBER,
                                                   bsp_pkg::ERR_NONE);
                        b.n = b.n + 2'd1;
                        do_ve = 1'b1;
                    end
                    else
                    begin
                        err_next   = bsp_pkg::ERR_BAD_NUM;
                        state_next = ST_ERROR;
                        b.ev[b.n]  = bsp_pkg::mk_ev(bsp_pkg::K_ERROR, 3'd0,
                                                    bsp_pkg::ERR_BAD_NUM);
                        b.n = b.n + 2'd1;
                    end
                end
                default:
                begin
                    b.n = 2'd0;
                end
            endcase

            // push onto the nesting stack
            if (do_push)
            begin
                if (push_ok)
                begin
                    top_next   = push_code;
                    count_next = count_reg + CNT_W'(1);
                end
                else
                begin
                    err_next   = bsp_pkg::ERR_TOO_DEEP;
                    state_next = ST_ERROR;
                    b.ev[b.n]  = bsp_pkg::mk_ev(bsp_pkg::K_ERROR, 3'd0,
                                                bsp_pkg::ERR_TOO_DEEP);
                    b.n = b.n + 2'd1;
                end
            end

            if (do_ve)
            begin
                state_next = ve_state;
                if (ve_has)
                begin
                    b.ev[b.n] = ve_ev;
                    b.n = b.n + 2'd1;
                end
                if (ve_pop)
                begin
                    count_next = count_reg - CNT_W'(1);
                    top_next   = below;
                end
                else
                begin
                    top_next = ve_top;
                end
            end

            // start of a value
            if (do_bv)
            begin
                if (data_byte == bsp_pkg::CH_D)
                begin
                    state_next = ST_DICT_KEY;
                    b.ev[b.n]  = bsp_pkg::mk_ev(bsp_pkg::K_BEGIN, bsp_pkg::E_DICT,
                                                bsp_pkg::ERR_NONE);
                    b.n = b.n + 2'd1;
                end
                else if (data_byte == bsp_pkg::CH_L)
                begin
                    state_next = ST_LIST;
                    b.ev[b.n]  = bsp_pkg::mk_ev(bsp_pkg::K_BEGIN, bsp_pkg::E_LIST,
                                                bsp_pkg::ERR_NONE);
                    b.n = b.n + 2'd1;
                end
                else if (data_byte == bsp_pkg::CH_I)
                begin
                    mag_next   = '0;
                    neg_next   = 1'b0;
                    dig_next   = 1'b0;
                    state_next = ST_NUM_SIGN;
                    b.ev[b.n]  = bsp_pkg::mk_ev(bsp_pkg::K_BEGIN, bsp_pkg::E_NUMBER,
                                                bsp_pkg::ERR_NONE);
                    b.n = b.n + 2'd1;
                end
                else if (is_dig)
                begin
                    len_next   = {{(ACC_W-4){1'b0}}, dval};
                    dig_next   = 1'b1;
                    state_next = ST_STR_LEN;
                    b.ev[b.n]  = bsp_pkg::mk_ev(bsp_pkg::K_BEGIN, bsp_pkg::E_STRING,
                                                bsp_pkg::ERR_NONE);
                    b.n = b.n + 2'd1;
                end
                else
                begin
                    err_next   = bsp_pkg::ERR_VAL_START;
                    state_next = ST_ERROR;
                    b.ev[b.n]  = bsp_pkg::mk_ev(bsp_pkg::K_ERROR, 3'd0,
                                                bsp_pkg::ERR_VAL_START);
                    b.n = b.n + 2'd1;
                end
            end
        end
        else if (req_type == bsp_pkg::REQ_CHECK)
        begin
            if (state_reg == ST_ERROR)
            begin
                b.ev[0] = bsp_pkg::mk_ev(bsp_pkg::K_ERROR, 3'd0, err_reg);
            end
            else if (state_reg == ST_FINISH || state_reg == ST_INITIAL)
            begin
                b.ev[0] = bsp_pkg::mk_ev(bsp_pkg::K_PASS, 3'd0, bsp_pkg::ERR_NONE);
            end
            else
            begin
                b.ev[0] = bsp_pkg::mk_ev(bsp_pkg::K_ERROR, 3'd0,
                                         bsp_pkg::ERR_PREMATURE);
            end
            b.n = 2'd1;
        end
        else if (req_type == bsp_pkg::REQ_RESTART)
        begin
            state_next = ST_INITIAL;
            count_next = CNT_W'(1);
            top_next   = bsp_pkg::N_BOTTOM;
            len_next   = '0;
            mag_next   = '0;
            neg_next   = 1'b0;
            dig_next   = 1'b0;
            err_next   = bsp_pkg::ERR_NONE;
        end

        if (!fire)
        begin
            state_next = state_reg;
            count_next = count_reg;
            top_next   = top_reg;
            len_next   = len_reg;
            mag_next   = mag_reg;
            neg_next   = neg_reg;
            dig_next   = dig_reg;
            err_next   = err_reg;
        end
    end

    assign q_push = fire && (b.n != 2'd0);
    assign q_data = b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INITIAL;
            count_reg     <= CNT_W'(1);
            top_reg       <= bsp_pkg::N_BOTTOM;
            len_reg       <= '0;
            mag_reg       <= '0;
            neg_reg       <= 1'b0;
            dig_reg       <= 1'b0;
            err_reg       <= bsp_pkg::ERR_NONE;
            limit_reg     <= bsp_pkg::DEPTH_LIMIT_RST;
            byp_valid_reg <= 1'b0;
            byp_data_reg  <= bsp_pkg::N_BOTTOM;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            top_reg       <= top_next;
            len_reg       <= len_next;
            mag_reg       <= mag_next;
            neg_reg       <= neg_next;
            dig_reg       <= dig_next;
            err_reg       <= err_next;
            byp_valid_reg <= push_w;
            if (push_w)
            begin
                byp_data_reg <= top_reg;
            end
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg >= CNT_W'(1) && CMP_W'(count_reg) <= CMP_W'(bsp_pkg::STACK_DEPTH))
        else $error("stack count out of range");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        fire && req_type == bsp_pkg::REQ_RESTART |=>
            state_reg == ST_INITIAL && count_reg == CNT_W'(1))
        else $error("restart did not clear parser");
`endif

endmodule
`default_nettype wire

// ----- design/bsp_evq.sv -----
// short queue of event bundles between front and back
`default_nettype none
module bsp_evq (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire bsp_pkg::bundle_t push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  head_valid,
    output bsp_pkg::bundle_t      head
);

    localparam int QPTR_W = bsp_pkg::QPTR_W;
    localparam int QCNT_W = bsp_pkg::QCNT_W;

    bsp_pkg::bundle_t        slots_reg [bsp_pkg::QDEPTH];
    logic [QPTR_W-1:0]       wr_reg;
    logic [QPTR_W-1:0]       rd_reg;
    logic [QCNT_W-1:0]       cnt_reg;
    logic                    do_pop;

    assign full       = cnt_reg == QCNT_W'(bsp_pkg::QDEPTH);
    assign head_valid = cnt_reg != '0;
    assign head       = slots_reg[rd_reg];
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_reg <= rd_reg + QPTR_W'(1);
            end
            if (push && !do_pop)
            begin
                cnt_reg <= cnt_reg + QCNT_W'(1);
            end
            else if (!push && do_pop)
            begin
                cnt_reg <= cnt_reg - QCNT_W'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push || do_pop)
        else $error("push into full event queue");
`endif

endmodule
`default_nettype wire

// ----- design/bsp_back.sv -----
// back part: splits bundles into single events behind an output register
`default_nettype none
module bsp_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             head_valid,
    input  wire bsp_pkg::bundle_t head,
    output logic                  pop,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [2:0]            event_kind,
    output logic [2:0]            element_type,
    output logic [7:0]            char_byte,
    output logic                  char_count,
    output logic signed [63:0]    number_value,
    output logic [2:0]            error_code,
    output logic                  last_of_run
);

    logic [1:0]          idx_reg;
    logic                out_valid_reg;
    logic [2:0]          kind_reg;
    logic [2:0]          etype_reg;
    logic [7:0]          chr_reg;
    logic                cnt_reg;
    logic [63:0]         num_reg;
    logic [2:0]          err_reg;
    logic                last_reg;
    logic                load;
    logic                is_last;
    bsp_pkg::ev_t        cur;

    assign load    = head_valid && (!out_valid_reg || out_ready);
    assign cur     = head.ev[idx_reg];
    assign is_last = idx_reg == (head.n - 2'd1);
    assign pop     = load && is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                idx_reg       <= is_last ? 2'd0 : idx_reg + 2'd1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg  <= cur.kind;
            etype_reg <= cur.etype;
            err_reg   <= cur.err;
            chr_reg   <= (cur.kind == bsp_pkg::K_CHARS) ? head.chr : 8'd0;
            cnt_reg   <= (cur.kind == bsp_pkg::K_CHARS) && head.cnt;
            num_reg   <= (cur.kind == bsp_pkg::K_NUMBER) ? head.num : 64'd0;
            last_reg  <= is_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign event_kind   = kind_reg;
    assign element_type = etype_reg;
    assign char_byte    = chr_reg;
    assign char_count   = cnt_reg;
    assign number_value = num_reg;
    assign error_code   = err_reg;
    assign last_of_run  = last_reg;

`ifndef SYNTHESIS
    a_idx_in_bundle: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> idx_reg < head.n)
        else $error("event index past bundle size");
`endif

endmodule
`default_nettype wire

// ----- design/bencode_stream_parser_top.sv -----
// top level of the bencode stream parser
//
// channel  direction  handshake             beat
// in       in         in_valid/in_ready     req_type, data_byte
// cfg      in         cfg_valid/cfg_ready   cfg_data (depth_limit)
// out      out        out_valid/out_ready   event_kind .. last_of_run
//
// one input beat per cycle while the queue is not full; the parser updates its state in that cycle
// a beat yields up to three events into a four-bundle queue
// the output side drains one event per cycle while out_ready is high, so sustained rate
// is one byte per cycle while each byte gives one event, slower by the extra events otherwise
// the nesting stack sits in a ram with the top entry held in a register
// reset is asynchronous, active low; no clearing pass is needed
`default_nettype none
module bencode_stream_parser_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         req_type,
    input  wire logic [7:0]         data_byte,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [6:0]         cfg_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [2:0]              event_kind,
    output logic [2:0]              element_type,
    output logic [7:0]              char_byte,
    output logic                    char_count,
    output logic signed [63:0]      number_value,
    output logic [2:0]              error_code,
    output logic                    last_of_run
);

    logic               q_full;
    logic               q_push;
    bsp_pkg::bundle_t   q_data;
    logic               q_pop;
    logic               head_valid;
    bsp_pkg::bundle_t   head;

    bsp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .data_byte (data_byte),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_data)
    );

    bsp_evq u_evq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_data),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head       (head)
    );

    bsp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .event_kind   (event_kind),
        .element_type (element_type),
        .char_byte    (char_byte),
        .char_count   (char_count),
        .number_value (number_value),
        .error_code   (error_code),
        .last_of_run  (last_of_run)
    );

endmodule
`default_nettype wire
